@@ hw/rtl/ray_depth_to_planar_depth_top_macros.svh @@
// Assertion macros used by the checker file.
`ifndef RAY_DEPTH_TO_PLANAR_DEPTH_TOP_MACROS_SVH
`define RAY_DEPTH_TO_PLANAR_DEPTH_TOP_MACROS_SVH

// Checked only outside reset.
`define RDPD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rdpd assertion failed");

// Checked during reset as well.
`define RDPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rdpd assertion failed");

`endif

@@ hw/rtl/rdpd_pkg.sv @@
package rdpd_pkg;

  localparam int COORD_BITS = 12;
  localparam int POS_W      = COORD_BITS + 4;
  localparam int RECIP_W    = 24;
  localparam int RAW_W      = 16;
  localparam int OUT_W      = 32;
  localparam int AX_W       = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS  = 41;
  localparam int DIV_CNT_W  = 6;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_WIDTH     = 3'd0,
    CFG_IMG_HEIGHT    = 3'd1,
    CFG_CENTER_X      = 3'd2,
    CFG_CENTER_Y      = 3'd3,
    CFG_RECIP_FOCAL_X = 3'd4,
    CFG_RECIP_FOCAL_Y = 3'd5,
    CFG_DEPTH_SCALE   = 3'd6
  } cfg_index_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_OFFS,
    BK_SQX,
    BK_SQY,
    BK_ROOT,
    BK_DIVLD,
    BK_DIV,
    BK_MLO,
    BK_MHI,
    BK_DONE,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [RAW_W-1:0]      raw;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  frame_end;
  } pix_entry_t;

  typedef struct packed {
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic [RECIP_W-1:0] recip_focal_x;
    logic [RECIP_W-1:0] recip_focal_y;
    logic [RECIP_W-1:0] depth_scale;
  } geom_cfg_t;

endpackage

@@ hw/rtl/rdpd_in_if.sv @@
interface rdpd_in_if import rdpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_depth;
  modport source (output valid, output raw_depth, input ready);
  modport sink (input valid, input raw_depth, output ready);
endinterface

@@ hw/rtl/rdpd_out_if.sv @@
interface rdpd_out_if import rdpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] planar_depth;
  logic             frame_end;
  modport source (output valid, output planar_depth, output frame_end, input ready);
  modport sink (input valid, input planar_depth, input frame_end, output ready);
endinterface

@@ hw/rtl/rdpd_cfg_if.sv @@
interface rdpd_cfg_if import rdpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/rdpd_queue.sv @@
module rdpd_queue import rdpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pix_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output pix_entry_t pop_data,
  output logic       empty
);

  pix_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push && !full) - QCNT_W'(pop && !empty);
    end
  end

endmodule

@@ hw/rtl/rdpd_front.sv @@
module rdpd_front import rdpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [12:0] img_width,
  input  logic [12:0] img_height,
  input  logic        in_valid,
  input  logic [RAW_W-1:0] in_raw,
  output logic        in_ready,
  output logic        push,
  output pix_entry_t  push_data,
  input  logic        full
);

  localparam logic [31:0] CntLimit = 32'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] col_count;
  logic [COORD_BITS-1:0] row_count;
  logic [31:0]           w_clamped;
  logic [31:0]           h_clamped;
  logic                  last_col;
  logic                  last_row;

  // Sizes of zero count as one; sizes above the counter range are clamped to it.
  always_comb begin
    w_clamped = 32'(img_width);
    h_clamped = 32'(img_height);
    if (w_clamped == '0) begin
      w_clamped = 32'd1;
    end else if (w_clamped > CntLimit) begin
      w_clamped = CntLimit;
    end
    if (h_clamped == '0) begin
      h_clamped = 32'd1;
    end else if (h_clamped > CntLimit) begin
      h_clamped = CntLimit;
    end
  end

  assign last_col = 32'(col_count) >= (w_clamped - 32'd1);
  assign last_row = 32'(row_count) >= (h_clamped - 32'd1);

  assign in_ready = !full;
  assign push     = in_valid && !full;

  always_comb begin
    push_data.raw       = in_raw;
    push_data.col       = col_count;
    push_data.row       = row_count;
    push_data.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (push) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/rdpd_back.sv @@
module rdpd_back import rdpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  geom_cfg_t        geom,
  input  logic             empty,
  input  pix_entry_t       pop_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_depth,
  output logic             out_frame_end
);

  localparam logic [63:0] AxMax = 64'h7FFF_FFFF;

  back_state_t state;
  back_state_t state_next;

  pix_entry_t                  item;
  logic [POS_W+RECIP_W-1:0]    axp;
  logic [POS_W+RECIP_W-1:0]    ayp;
  logic [RAW_W+RECIP_W-1:0]    m;
  logic [2*AX_W-1:0]           sqx;
  logic [63:0]                 sq_rem;
  logic [63:0]                 sq_res;
  logic [63:0]                 sq_bit;
  logic [32:0]                 dv_rem;
  logic [40:0]                 dq;
  logic [DIV_CNT_W-1:0]        dv_cnt;
  logic [44:0]                 p_lo;
  logic [44:0]                 p_hi;

  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [POS_W-1:0]  ux;
  logic [POS_W-1:0]  uy;
  logic [63:0]       axs;
  logic [63:0]       ays;
  logic [AX_W-1:0]   ax;
  logic [AX_W-1:0]   ay;
  logic [2*AX_W-1:0] ay_sq;
  logic [63:0]       root_try;
  logic [32:0]       dv_shift;
  logic [31:0]       root_r;
  logic [65:0]       prod_sum;

  assign pos_x = {item.col, 4'b0000};
  assign pos_y = {item.row, 4'b0000};
  assign ux = (pos_x >= geom.center_x) ? pos_x - geom.center_x : geom.center_x - pos_x;
  assign uy = (pos_y >= geom.center_y) ? pos_y - geom.center_y : geom.center_y - pos_y;

  assign axs = 64'(axp >> 12);
  assign ays = 64'(ayp >> 12);
  assign ax  = (axs > AxMax) ? AX_W'(AxMax) : axs[AX_W-1:0];
  assign ay  = (ays > AxMax) ? AX_W'(AxMax) : ays[AX_W-1:0];
  assign ay_sq = ay * ay;

  assign root_try = sq_res + sq_bit;
  assign root_r   = sq_res[31:0];
  assign dv_shift = {dv_rem[31:0], dq[40]};
  assign prod_sum = {1'b0, p_hi, 20'b0} + 66'(p_lo) + (66'(1) << 31);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (!empty) state_next = BK_OFFS;
      BK_OFFS:  state_next = BK_SQX;
      BK_SQX:   state_next = BK_SQY;
      BK_SQY:   state_next = BK_ROOT;
      BK_ROOT:  if (sq_bit[0]) state_next = BK_DIVLD;
      BK_DIVLD: state_next = BK_DIV;
      BK_DIV:   if (dv_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = BK_MLO;
      BK_MLO:   state_next = BK_MHI;
      BK_MHI:   state_next = BK_DONE;
      BK_DONE:  state_next = BK_OUT;
      BK_OUT:   if (out_ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == BK_IDLE) && !empty;
    out_valid = (state == BK_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        item <= pop_data;
      end
      BK_OFFS: begin
        axp <= ux * geom.recip_focal_x;
        ayp <= uy * geom.recip_focal_y;
        m   <= item.raw * geom.depth_scale;
      end
      BK_SQX: begin
        sqx <= ax * ax;
      end
      BK_SQY: begin
        sq_rem <= 64'(sqx) + 64'(ay_sq) + (64'(1) << 32);
        sq_res <= '0;
        sq_bit <= 64'(1) << 62;
      end
      BK_ROOT: begin
        // One result bit of the integer square root per cycle.
        if (sq_rem >= root_try) begin
          sq_rem <= sq_rem - root_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      BK_DIVLD: begin
        dq     <= (41'(1) << 40) + 41'(root_r >> 1);
        dv_rem <= '0;
        dv_cnt <= '0;
      end
      BK_DIV: begin
        // Restoring division: the dividend shifts out as quotient bits shift in.
        if (dv_shift >= 33'(root_r)) begin
          dv_rem <= dv_shift - 33'(root_r);
          dq     <= {dq[39:0], 1'b1};
        end else begin
          dv_rem <= dv_shift;
          dq     <= {dq[39:0], 1'b0};
        end
        dv_cnt <= dv_cnt + 1'b1;
      end
      BK_MLO: begin
        p_lo <= m[19:0] * dq[24:0];
      end
      BK_MHI: begin
        p_hi <= m[39:20] * dq[24:0];
      end
      BK_DONE: begin
        out_depth     <= (prod_sum[65:64] != 2'b00) ? '1 : prod_sum[63:32];
        out_frame_end <= item.frame_end;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/ray_depth_to_planar_depth_top.sv @@
// Converts ray-length depth samples, in raster order, to planar depth in
// unsigned Q16.16 metres and flags the last pixel of each frame. Pixels are
// taken into a two-entry queue while it has room; the back end then works on
// one pixel at a time (the bit-per-cycle square root, the bit-per-cycle
// reciprocal division, then the multiplies, rounding and handover) and takes
// the next pixel from the queue only once the output side has accepted the
// result. Configuration writes are accepted in every cycle and should be
// made only while no pixel is in flight.
module ray_depth_to_planar_depth_top import rdpd_pkg::*; (
  input logic         clk,
  input logic         rst,
  rdpd_cfg_if.sink    cfg,
  rdpd_in_if.sink     pixel_in,
  rdpd_out_if.source  depth_out
);

  logic [12:0] img_width;
  logic [12:0] img_height;
  geom_cfg_t   geom;
  logic        push;
  pix_entry_t  push_data;
  logic        full;
  logic        pop;
  pix_entry_t  pop_data;
  logic        empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width          <= 13'd320;
      img_height         <= 13'd240;
      geom.center_x      <= 16'd2560;
      geom.center_y      <= 16'd1920;
      geom.recip_focal_x <= 24'd60540;
      geom.recip_focal_y <= 24'd57910;
      geom.depth_scale   <= 24'd16777;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IMG_WIDTH:     img_width          <= cfg.data[12:0];
        CFG_IMG_HEIGHT:    img_height         <= cfg.data[12:0];
        CFG_CENTER_X:      geom.center_x      <= cfg.data[15:0];
        CFG_CENTER_Y:      geom.center_y      <= cfg.data[15:0];
        CFG_RECIP_FOCAL_X: geom.recip_focal_x <= cfg.data;
        CFG_RECIP_FOCAL_Y: geom.recip_focal_y <= cfg.data;
        CFG_DEPTH_SCALE:   geom.depth_scale   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  rdpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .img_width  (img_width),
    .img_height (img_height),
    .in_valid   (pixel_in.valid),
    .in_raw     (pixel_in.raw_depth),
    .in_ready   (pixel_in.ready),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  rdpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  rdpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .geom          (geom),
    .empty         (empty),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (depth_out.valid),
    .out_ready     (depth_out.ready),
    .out_depth     (depth_out.planar_depth),
    .out_frame_end (depth_out.frame_end)
  );

endmodule

@@ hw/rtl/rdpd_checker.sv @@
`include "ray_depth_to_planar_depth_top_macros.svh"

module rdpd_checker import rdpd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] planar_depth
);

  // Reset leaves the queue empty and no result pending.
  `RDPD_ASSERT_ALWAYS(a_reset_no_out, clk, rst |=> !out_valid)
  `RDPD_ASSERT_ALWAYS(a_reset_ready, clk, rst |=> in_ready)
  // After a result transfer the back end passes through idle before the next one.
  `RDPD_ASSERT(a_gap_after_out, clk, rst,
    (out_valid && out_ready) |=> !out_valid)
  `RDPD_ASSERT(a_hold_depth, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(planar_depth)))

endmodule

bind ray_depth_to_planar_depth_top rdpd_checker u_rdpd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pixel_in.ready),
  .out_valid    (depth_out.valid),
  .out_ready    (depth_out.ready),
  .planar_depth (depth_out.planar_depth)
);
